// ===== src/bod_pkg.sv =====
// Shared types and codes for the bounded ordered deque.
// No dependencies; compiled first.
package bod_pkg;

  // Request and response field widths fixed by the channel definition
  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;

  typedef logic [2:0] opcode_t;

  localparam opcode_t OP_ADD_FRONT     = 3'd0;
  localparam opcode_t OP_ADD_REAR      = 3'd1;
  localparam opcode_t OP_REMOVE_FRONT  = 3'd2;
  localparam opcode_t OP_REMOVE_REAR   = 3'd3;
  localparam opcode_t OP_SEARCH        = 3'd4;
  localparam opcode_t OP_DELETE        = 3'd5;
  localparam opcode_t OP_SORTED_INSERT = 3'd6;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // Commands from the sequencer to the ring store
  typedef struct packed {
    logic wr;          // write wr_data at logical index wr_idx
    logic push_front;  // write wr_data ahead of the front, move head back
    logic pop_front;   // drop the front entry, move head forward
  } ring_cmd_t;

endpackage

// ===== src/bod_if.sv =====
// Valid/ready channel interfaces for the deque request and response.
// Depends on bod_pkg.
interface bod_req_if;
  logic                                valid;
  logic                                ready;
  bod_pkg::opcode_t                    opcode;
  logic signed [bod_pkg::DATA_W-1:0]   element;

  modport source (output valid, opcode, element, input ready);
  modport sink   (input valid, opcode, element, output ready);
endinterface

interface bod_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [bod_pkg::DATA_W-1:0]   removed_value;
  logic                                found;
  bod_pkg::status_t                    status;
  logic [bod_pkg::OCC_W-1:0]           occupancy;

  modport source (output valid, removed_value, found, status, occupancy, input ready);
  modport sink   (input valid, removed_value, found, status, occupancy, output ready);
endinterface

// ===== src/bod_ring.sv =====
// Circular element store: one synchronous RAM plus the head pointer.
// Logical index 0 is the front. Depends on bod_pkg.
module bod_ring #(
  parameter int CAPACITY      = 16,
  parameter int ELEMENT_WIDTH = 32,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  bod_pkg::ring_cmd_t       cmd,
  input  logic [CW-1:0]            rd_idx,
  input  logic [CW-1:0]            wr_idx,
  input  logic [ELEMENT_WIDTH-1:0] wr_data,
  output logic [ELEMENT_WIDTH-1:0] rd_data
);

  localparam int SW = CW + 1;

  logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];
  logic [AW-1:0]            head;
  logic [AW-1:0]            head_prev;
  logic [AW-1:0]            head_succ;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            wr_addr;
  logic                     we;

  // head + idx, wrapped once; idx never exceeds CAPACITY
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] idx);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(idx);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return AW'(s);
  endfunction

  assign head_prev = (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);
  assign head_succ = (head == AW'(CAPACITY - 1)) ? '0 : head + AW'(1);
  assign rd_addr   = phys(head, rd_idx);
  assign wr_addr   = cmd.push_front ? head_prev : phys(head, wr_idx);
  assign we        = cmd.wr | cmd.push_front;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (cmd.push_front) begin
      head <= head_prev;
    end else if (cmd.pop_front) begin
      head <= head_succ;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/bounded_ordered_deque.sv =====
// Bounded ordered deque: top level with the operation sequencer.
// Depends on bod_pkg, bod_if (bod_req_if, bod_rsp_if) and bod_ring.
//
// Usage
//   req channel (valid/ready): opcode + signed element. A request is taken
//   when valid and ready are both high; ready is high whenever the block
//   is idle, even while the previous response still waits on rsp.
//   rsp channel (valid/ready): removed_value, found, status, occupancy;
//   exactly one response per request, in request order.
//   Elements live in one single-port-read, single-port-write RAM used as
//   a ring (head pointer), so front and rear operations need no moves.
// Steps, state by state (receiver not stalling)
//   add front / add rear / remove front / remove rear / errors: idle,
//   dispatch, post; search or delete add one scan step per entry compared,
//     and delete one move step per entry moved toward the front behind the match
//   sorted insert: at front as add front, at rear plus a rear check; else
//     rear check, one scan step per entry compared, read prime, one move
//     step per entry moved back by one, then the insert write. The RAM does
//   one read and one write per cycle with registered read data, entries scanned and moved one per cycle.
// Reset (rst, synchronous): list empty, no response pending; the RAM is
//   not cleared, entries at or above the current count are never used.
// Stall: a finished response parks in a holding register until the
//   output register frees up; no new request is taken meanwhile.
module bounded_ordered_deque #(
  parameter int CAPACITY      = 16,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  bod_req_if.sink    req,
  bod_rsp_if.source  rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = ELEMENT_WIDTH;
  localparam int DW = bod_pkg::DATA_W;
  localparam int OW = bod_pkg::OCC_W;

  typedef enum logic [3:0] {
    S_IDLE,     // waiting for a request; RAM read issued from the request
    S_EXEC,     // front/rear data available, dispatch
    S_SCAN,     // search / delete: compare one entry per cycle
    S_SHDN,     // delete: move entries behind the match one toward front
    S_SI_TAIL,  // sorted insert: check rear entry
    S_SI_SCAN,  // sorted insert: find first entry not below the element
    S_SHUP_RD,  // sorted insert: prime read of the rear entry
    S_SHUP,     // sorted insert: move entries one toward rear
    S_INS_WR,   // sorted insert: drop the element into the hole
    S_POST      // response waits for the output register
  } state_t;

  state_t                   state, state_next;
  bod_pkg::opcode_t         op_q;
  logic [EW-1:0]            el_q;
  logic [CW-1:0]            count, count_next;
  logic [CW-1:0]            cmp_idx, cmp_idx_next;  // scan position, later insert slot
  logic [CW-1:0]            sh_idx, sh_idx_next;    // move destination

  // ring store interface
  bod_pkg::ring_cmd_t       cmd;
  logic [CW-1:0]            rd_idx;
  logic [CW-1:0]            wr_idx;
  logic [EW-1:0]            wr_data;
  logic [EW-1:0]            rd_data;

  // finishing response, held until the output register is free
  logic                     fin;
  logic [DW-1:0]            fin_removed;
  logic                     fin_found;
  bod_pkg::status_t         fin_status;
  logic [DW-1:0]            res_removed;
  logic                     res_found;
  bod_pkg::status_t         res_status;
  logic [OW-1:0]            res_occ;

  // output register
  logic                     out_valid;
  logic [DW-1:0]            out_removed;
  logic                     out_found;
  bod_pkg::status_t         out_status;
  logic [OW-1:0]            out_occ;
  logic                     out_free;

  logic [CW-1:0]            count_last;
  logic                     full;
  logic                     empty;
  logic                     el_lt_rd;
  logic                     rd_lt_el;
  logic                     match;

  // sign-extend (or cut) a stored element to the response width
  function automatic logic [DW-1:0] widen(input logic [EW-1:0] v);
    logic signed [EW-1:0] s;
    s = v;
    return DW'(s);
  endfunction

  bod_ring #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_idx  (rd_idx),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign count_last = count - CW'(1);
  assign full       = (count == CW'(CAPACITY));
  assign empty      = (count == '0);
  assign el_lt_rd   = $signed(el_q) < $signed(rd_data);
  assign rd_lt_el   = $signed(rd_data) < $signed(el_q);
  assign match      = (rd_data == el_q);
  assign out_free   = !out_valid || rsp.ready;

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.removed_value = out_removed;
  assign rsp.found         = out_found;
  assign rsp.status        = out_status;
  assign rsp.occupancy     = out_occ;

  // Sequencer: RAM addressing, writes and next state. A move never reads
  // the entry it writes in one cycle: moves read two places ahead/behind.
  always_comb begin
    state_next   = state;
    count_next   = count;
    cmp_idx_next = cmp_idx;
    sh_idx_next  = sh_idx;
    cmd          = '0;
    rd_idx       = '0;
    wr_idx       = count;
    wr_data      = el_q;
    fin          = 1'b0;
    fin_removed  = '0;
    fin_found    = 1'b0;
    fin_status   = bod_pkg::ST_OK;

    unique case (state)
      S_IDLE: begin
        // rear removal needs the last entry; everything else starts at front
        if (req.opcode == bod_pkg::OP_REMOVE_REAR && !empty) begin
          rd_idx = count_last;
        end
        if (req.valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        case (op_q) inside
          bod_pkg::OP_ADD_FRONT, bod_pkg::OP_ADD_REAR, bod_pkg::OP_SORTED_INSERT: begin
            if (full) begin
              fin        = 1'b1;
              fin_status = bod_pkg::ST_FULL;
            end else if (op_q == bod_pkg::OP_ADD_FRONT ||
                         (op_q == bod_pkg::OP_SORTED_INSERT && (empty || el_lt_rd))) begin
              cmd.push_front = 1'b1;
              count_next     = count + CW'(1);
              fin            = 1'b1;
            end else if (op_q == bod_pkg::OP_ADD_REAR) begin
              cmd.wr     = 1'b1;
              count_next = count + CW'(1);
              fin        = 1'b1;
            end else begin
              rd_idx     = count_last;
              state_next = S_SI_TAIL;
            end
          end
          bod_pkg::OP_REMOVE_FRONT, bod_pkg::OP_REMOVE_REAR: begin
            fin = 1'b1;
            if (empty) begin
              fin_status = bod_pkg::ST_EMPTY;
            end else begin
              fin_removed   = widen(rd_data);
              count_next    = count_last;
              cmd.pop_front = (op_q == bod_pkg::OP_REMOVE_FRONT);
            end
          end
          bod_pkg::OP_SEARCH, bod_pkg::OP_DELETE: begin
            if (empty) begin
              fin = 1'b1;
            end else begin
              cmp_idx_next = '0;
              state_next   = S_SCAN;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      S_SCAN: begin
        rd_idx = cmp_idx + CW'(1);
        if (match) begin
          fin_found = 1'b1;
          if (op_q == bod_pkg::OP_SEARCH) begin
            fin = 1'b1;
          end else if (cmp_idx == '0) begin
            cmd.pop_front = 1'b1;
            count_next    = count_last;
            fin           = 1'b1;
          end else if (cmp_idx == count_last) begin
            count_next = count_last;
            fin        = 1'b1;
          end else begin
            // entry behind the match is being read now
            sh_idx_next = cmp_idx;
            state_next  = S_SHDN;
          end
        end else if (cmp_idx == count_last) begin
          fin = 1'b1;
        end else begin
          cmp_idx_next = cmp_idx + CW'(1);
        end
      end

      S_SHDN: begin
        cmd.wr  = 1'b1;
        wr_idx  = sh_idx;
        wr_data = rd_data;
        rd_idx  = sh_idx + CW'(2);
        if (sh_idx + CW'(2) == count) begin
          count_next = count_last;
          fin_found  = 1'b1;
          fin        = 1'b1;
        end else begin
          sh_idx_next = sh_idx + CW'(1);
        end
      end

      S_SI_TAIL: begin
        rd_idx = CW'(1);
        if (rd_lt_el || count == CW'(1)) begin
          cmd.wr     = 1'b1;
          count_next = count + CW'(1);
          fin        = 1'b1;
        end else begin
          cmp_idx_next = CW'(1);
          state_next   = S_SI_SCAN;
        end
      end

      S_SI_SCAN: begin
        rd_idx = cmp_idx + CW'(1);
        if (!rd_lt_el) begin
          state_next = S_SHUP_RD;
        end else if (cmp_idx == count_last) begin
          cmd.wr     = 1'b1;
          count_next = count + CW'(1);
          fin        = 1'b1;
        end else begin
          cmp_idx_next = cmp_idx + CW'(1);
        end
      end

      S_SHUP_RD: begin
        rd_idx      = count_last;
        sh_idx_next = count;
        state_next  = S_SHUP;
      end

      S_SHUP: begin
        cmd.wr  = 1'b1;
        wr_idx  = sh_idx;
        wr_data = rd_data;
        rd_idx  = sh_idx - CW'(2);
        if (sh_idx - CW'(1) == cmp_idx) begin
          state_next = S_INS_WR;
        end else begin
          sh_idx_next = sh_idx - CW'(1);
        end
      end

      S_INS_WR: begin
        cmd.wr     = 1'b1;
        wr_idx     = cmp_idx;
        count_next = count + CW'(1);
        fin        = 1'b1;
      end

      S_POST: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      state_next = S_POST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      cmp_idx <= cmp_idx_next;
      sh_idx  <= sh_idx_next;

      if (state == S_IDLE && req.valid) begin
        op_q <= req.opcode;
        el_q <= EW'(req.element);
      end

      if (fin) begin
        res_removed <= fin_removed;
        res_found   <= fin_found;
        res_status  <= fin_status;
        res_occ     <= OW'(count_next);
      end

      if (state == S_POST && out_free) begin
        out_valid   <= 1'b1;
        out_removed <= res_removed;
        out_found   <= res_found;
        out_status  <= res_status;
        out_occ     <= res_occ;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == bod_pkg::ST_FULL |-> rsp.occupancy == OW'(CAPACITY))
    else $error("full status without a full list");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found |-> rsp.status == bod_pkg::ST_OK && rsp.removed_value == '0)
    else $error("match reported together with an error or removal");

  a_quiet_ram: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE || state == S_POST |-> !cmd.wr && !cmd.push_front && !cmd.pop_front)
    else $error("store modified outside an operation");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |=> count == $past(count) || count == $past(count) + CW'(1) ||
                        count == $past(count) - CW'(1))
    else $error("count moved by more than one");
`endif

endmodule

// ===== sim/bod_response_checker.sv =====
// Response checker for the bounded ordered deque testbench.
// Depends on bod_pkg and bod_if; mirrors the list contents from the request
// channel and compares every response with the predicted one.
module bod_response_checker #(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  bod_req_if   req_mon,
  bod_rsp_if   rsp_mon,
  output int   mismatches,
  output int   outstanding,
  output int   requests_seen,
  output int   full_refusals,
  output int   empty_removals,
  output int   value_matches
);
  import bod_pkg::*;

  localparam int MAX_PRINTED = 20;

  typedef struct {
    logic signed [DATA_W-1:0] removed_value;
    logic                     found;
    status_t                  status;
    logic [OCC_W-1:0]         occupancy;
  } deque_result_t;

  // Mirror of the list, front at index 0
  logic signed [DATA_W-1:0] held_elems[$];
  deque_result_t            pending_results[$];
  int                       responses_seen;

  function automatic deque_result_t apply_request(input opcode_t op,
                                                  input logic signed [DATA_W-1:0] el);
    deque_result_t r;
    int            pos;
    bit            hit;
    r.removed_value = '0;
    r.found         = 1'b0;
    r.status        = ST_OK;
    case (op)
      OP_ADD_FRONT, OP_ADD_REAR, OP_SORTED_INSERT: begin
        if (held_elems.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (op == OP_ADD_FRONT) begin
          held_elems.push_front(el);
        end else if (op == OP_ADD_REAR) begin
          held_elems.push_back(el);
        end else if (held_elems.size() == 0 || el < held_elems[0]) begin
          held_elems.push_front(el);
        end else if (held_elems[held_elems.size()-1] < el) begin
          held_elems.push_back(el);
        end else begin
          // scan starts past the front: the front is known not above el
          pos = 1;
          while (pos < held_elems.size() && held_elems[pos] < el) pos++;
          held_elems.insert(pos, el);
        end
      end
      OP_REMOVE_FRONT, OP_REMOVE_REAR: begin
        if (held_elems.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_REMOVE_FRONT) begin
          r.removed_value = held_elems.pop_front();
        end else begin
          r.removed_value = held_elems.pop_back();
        end
      end
      OP_SEARCH, OP_DELETE: begin
        pos = 0;
        hit = 1'b0;
        while (!hit && pos < held_elems.size()) begin
          if (held_elems[pos] == el) hit = 1'b1;
          else pos++;
        end
        if (hit) begin
          r.found = 1'b1;
          if (op == OP_DELETE) held_elems.delete(pos);
        end
      end
      default: ;
    endcase
    r.occupancy = OCC_W'(held_elems.size());
    return r;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin : watch
    deque_result_t want;
    if (rst) begin
      held_elems.delete();
      pending_results.delete();
      mismatches     = 0;
      requests_seen  = 0;
      responses_seen = 0;
      full_refusals  = 0;
      empty_removals = 0;
      value_matches  = 0;
      outstanding   <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        want = apply_request(req_mon.opcode, req_mon.element);
        pending_results.push_back(want);
        requests_seen++;
        if (want.status == ST_FULL) full_refusals++;
        if (want.status == ST_EMPTY) empty_removals++;
        if (want.found) value_matches++;
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        responses_seen++;
        if (pending_results.size() == 0) begin
          report($sformatf("response %0d arrived with no request waiting", responses_seen));
        end else begin
          want = pending_results.pop_front();
          if (rsp_mon.removed_value !== want.removed_value)
            report($sformatf("response %0d removed_value %0d, predicted %0d",
                             responses_seen, rsp_mon.removed_value, want.removed_value));
          if (rsp_mon.found !== want.found)
            report($sformatf("response %0d found %0b, predicted %0b",
                             responses_seen, rsp_mon.found, want.found));
          if (rsp_mon.status !== want.status)
            report($sformatf("response %0d status %0d, predicted %0d",
                             responses_seen, rsp_mon.status, want.status));
          if (rsp_mon.occupancy !== want.occupancy)
            report($sformatf("response %0d occupancy %0d, predicted %0d",
                             responses_seen, rsp_mon.occupancy, want.occupancy));
        end
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

// ===== sim/tb_bounded_ordered_deque.sv =====
// Testbench top for the bounded ordered deque: clock, reset, request
// stimulus, response back-pressure and the verdict.
// Depends on bod_pkg, bod_if, bounded_ordered_deque and bod_response_checker.
module tb_bounded_ordered_deque;
  import bod_pkg::*;

  localparam int DEPTH         = 16;
  localparam int RESET_CYCLES  = 4;
  localparam int PHASES        = 18;
  localparam int PHASE_LEN     = 40;
  localparam int HOLD_PHASE    = 4;    // phase that opens with a long response hold
  localparam int PAUSE_PHASE   = 9;    // phase that opens after a full drain
  localparam int BURST         = 12;   // requests offered during the hold
  localparam int HOLD_CYCLES   = 120;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 500_000;
  localparam int RECENT        = 16;

  // Opcode 7 is not defined by the block; it must leave the list alone
  localparam opcode_t OP_UNUSED = 3'd7;

  localparam logic signed [DATA_W-1:0] ELEM_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] ELEM_MAX = 32'sh7fff_ffff;

  // Operation mix of one random phase
  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_SORTED} mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bit   calm;          // phase with no request gaps and no random response stalls
  int   hold_reqs;     // bumped by the stimulus to ask for a long response hold
  int   cycle_count;

  // Values recently added, so searches and deletes hit often
  bit signed [DATA_W-1:0] recent_adds[RECENT];
  int                     recent_ptr;

  int mismatches, outstanding, requests_seen;
  int full_refusals, empty_removals, value_matches;

  bod_req_if req_ch ();
  bod_rsp_if rsp_ch ();

  bounded_ordered_deque #(
    .CAPACITY      (DEPTH),
    .ELEMENT_WIDTH (DATA_W)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  bod_response_checker #(
    .CAPACITY (DEPTH)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_mon        (req_ch),
    .rsp_mon        (rsp_ch),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .requests_seen  (requests_seen),
    .full_refusals  (full_refusals),
    .empty_removals (empty_removals),
    .value_matches  (value_matches)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: any hang ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses still due", cycle_count, outstanding);
      $display("simulation failed");
      $finish;
    end
  end

  // Response side: mostly ready, short stalls, a few long ones; a hold
  // request from the stimulus forces one long stall counted here.
  initial begin : rsp_side
    int  stall_left;
    int  hold_seen;
    int  r;
    bit  nxt;
    stall_left = 0;
    hold_seen  = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen  = hold_reqs;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b0;
      end else if (calm) begin
        nxt = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          nxt = 1'b1;
        end else if (r < 95) begin
          stall_left = $urandom_range(0, 3);
          nxt = 1'b0;
        end else begin
          stall_left = $urandom_range(10, 40);
          nxt = 1'b0;
        end
      end
      rsp_ch.ready <= nxt;
    end
  end

  // Small values (collisions, equal keys), some extremes, the other half full range
  function automatic logic signed [DATA_W-1:0] pick_element();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $signed($urandom_range(0, 16)) - 8;
    if (r < 50) begin
      case ($urandom_range(0, 5))
        0:       return ELEM_MIN;
        1:       return ELEM_MAX;
        2:       return ELEM_MIN + 1;
        3:       return ELEM_MAX - 1;
        4:       return '0;
        default: return -1;
      endcase
    end
    return $urandom();
  endfunction

  // Offer one request, wait for the handshake, then maybe leave a gap.
  // valid stays high when the next request follows at once.
  task automatic send_req(input opcode_t op, input logic signed [DATA_W-1:0] el,
                          input bit no_gap);
    int gap;
    int r;
    req_ch.valid   <= 1'b1;
    req_ch.opcode  <= op;
    req_ch.element <= el;
    do @(posedge clk); while (!req_ch.ready);
    r = $urandom_range(0, 99);
    if (no_gap || calm || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_request(input mix_t mode, input bit no_gap);
    int                       r;
    opcode_t                  op;
    logic signed [DATA_W-1:0] el;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:
        op = (r < 30) ? OP_ADD_FRONT    : (r < 55) ? OP_ADD_REAR :
             (r < 80) ? OP_SORTED_INSERT : (r < 85) ? OP_REMOVE_FRONT :
             (r < 90) ? OP_REMOVE_REAR  : (r < 94) ? OP_SEARCH :
             (r < 98) ? OP_DELETE       : OP_UNUSED;
      MODE_DRAIN:
        op = (r < 5)  ? OP_ADD_FRONT    : (r < 10) ? OP_ADD_REAR :
             (r < 15) ? OP_SORTED_INSERT : (r < 55) ? OP_REMOVE_FRONT :
             (r < 89) ? OP_REMOVE_REAR  : (r < 94) ? OP_SEARCH :
             (r < 99) ? OP_DELETE       : OP_UNUSED;
      MODE_SORTED:
        // keeps the list ordered so inserts land in the middle
        op = (r < 55) ? OP_SORTED_INSERT : (r < 70) ? OP_DELETE :
             (r < 80) ? OP_SEARCH       : (r < 90) ? OP_REMOVE_FRONT :
             OP_REMOVE_REAR;
      default:
        op = (r < 14) ? OP_ADD_FRONT    : (r < 28) ? OP_ADD_REAR :
             (r < 44) ? OP_SORTED_INSERT : (r < 56) ? OP_REMOVE_FRONT :
             (r < 68) ? OP_REMOVE_REAR  : (r < 80) ? OP_SEARCH :
             (r < 96) ? OP_DELETE       : OP_UNUSED;
    endcase
    if ((op == OP_SEARCH || op == OP_DELETE) && $urandom_range(0, 99) < 65)
      el = recent_adds[$urandom_range(0, RECENT-1)];
    else
      el = pick_element();
    if (op == OP_ADD_FRONT || op == OP_ADD_REAR || op == OP_SORTED_INSERT) begin
      recent_adds[recent_ptr] = el;
      recent_ptr = (recent_ptr + 1) % RECENT;
    end
    send_req(op, el, no_gap);
  endtask

  // Drop valid and wait until every response has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    mix_t mode;
    int   phase;
    req_ch.valid   <= 1'b0;
    req_ch.opcode  <= OP_ADD_FRONT;
    req_ch.element <= '0;
    calm           <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list corners, unused opcode, extremes, sorted insert
    // into empty / front / rear / middle / equal key, hits and misses.
    send_req(OP_REMOVE_FRONT, ELEM_MAX, 1'b0);    // empty removal
    send_req(OP_REMOVE_REAR, ELEM_MIN, 1'b0);     // empty removal
    send_req(OP_SEARCH, '0, 1'b0);                // search on empty
    send_req(OP_DELETE, '0, 1'b0);                // delete on empty
    send_req(OP_UNUSED, ELEM_MAX, 1'b0);
    send_req(OP_SORTED_INSERT, 7, 1'b0);          // into empty list
    send_req(OP_SORTED_INSERT, 3, 1'b0);          // below front
    send_req(OP_SORTED_INSERT, 9, 1'b0);          // above rear
    send_req(OP_SORTED_INSERT, 7, 1'b0);          // equal key, middle
    send_req(OP_ADD_FRONT, ELEM_MIN, 1'b0);
    send_req(OP_ADD_REAR, ELEM_MAX, 1'b0);
    send_req(OP_SORTED_INSERT, 5, 1'b0);          // middle scan
    send_req(OP_SEARCH, 9, 1'b0);
    send_req(OP_SEARCH, 100, 1'b0);
    send_req(OP_DELETE, 7, 1'b0);                 // first of two equal keys
    send_req(OP_DELETE, 100, 1'b0);               // no match
    send_req(OP_REMOVE_FRONT, '0, 1'b0);          // takes the minimum
    send_req(OP_REMOVE_REAR, '0, 1'b0);           // takes the maximum
    send_req(OP_ADD_FRONT, -1, 1'b0);
    send_req(OP_ADD_REAR, 32'sh5555_5555, 1'b0);
    send_req(OP_UNUSED, ELEM_MIN, 1'b0);          // on a non-empty list
    send_req(OP_SORTED_INSERT, -1, 1'b0);         // equal to front

    // Random phases: first a fill to full, then a drain past empty
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) mode = MODE_FILL;
      else if (phase == 1) mode = MODE_DRAIN;
      else mode = mix_t'($urandom_range(0, 3));
      calm <= (phase > 1) && ($urandom_range(0, 3) == 0);
      if (phase == HOLD_PHASE) begin
        // receiver holds off while requests keep coming: the block backs up
        hold_reqs <= hold_reqs + 1;
        repeat (BURST) random_request(MODE_MIXED, 1'b1);
      end
      if (phase == PAUSE_PHASE) wait_drained();
      repeat (PHASE_LEN) random_request(mode, 1'b0);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d requests checked: %0d adds refused on a full list, %0d removals on empty,",
             requests_seen, full_refusals, empty_removals);
    $display("%0d value matches; fill, drain, sorted and mixed phases with holds and pauses",
             value_matches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bod_pkg.sv
src/bod_if.sv
src/bod_ring.sv
src/bounded_ordered_deque.sv
sim/bod_response_checker.sv
sim/tb_bounded_ordered_deque.sv
